FILE: design/hrec_pkg.sv
`default_nettype none

package hrec_pkg;

   // 8-bit result: quotient bits resolved one per step, scale factor is 2^8 - 1
   localparam int QUOT_BITS = 8;
   localparam int QIDX_BITS = 3;

   typedef struct packed {
      logic                 clear;
      logic                 load;
      logic                 step;
      logic                 last;
      logic [QIDX_BITS-1:0] bit_idx;
   } lane_ctrl_type;

endpackage

`default_nettype wire

FILE: design/hrec_lane.sv
`default_nettype none

module hrec_lane #(
   parameter int SAMPLE_BITS = 20,
   parameter int MAX_BITS    = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire hrec_pkg::lane_ctrl_type       ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0] colour,
   input  wire logic signed [SAMPLE_BITS-1:0] offset,
   input  wire logic        [MAX_BITS-1:0]    maxv,
   output logic             [hrec_pkg::QUOT_BITS-1:0] quot
);
   import hrec_pkg::*;

   localparam int REM_W = MAX_BITS + QUOT_BITS + 1;
   localparam int CMP_W = ((SAMPLE_BITS > MAX_BITS) ? SAMPLE_BITS : MAX_BITS) + 2;

   logic        [MAX_BITS-1:0]  residual_ff, residual_in;
   logic        [REM_W-1:0]     rem_ff, rem_in;
   logic        [QUOT_BITS-1:0] quot_ff, quot_in;

   logic signed [CMP_W-1:0]     sum;
   logic signed [CMP_W-1:0]     max_ext;
   logic        [MAX_BITS-1:0]  clamped;
   logic        [MAX_BITS-1:0]  res_use;
   logic        [REM_W-1:0]     scaled;
   logic        [REM_W-1:0]     div_sh;
   logic        [REM_W:0]       diff;
   logic                        fits;

   // clamp colour + offset to 0..max
   always_comb begin
      sum     = CMP_W'(colour) + CMP_W'(offset);
      max_ext = signed'(CMP_W'(maxv));
      if (sum < 0) begin
         clamped = '0;
      end else if (sum > max_ext) begin
         clamped = maxv;
      end else begin
         clamped = sum[MAX_BITS-1:0];
      end
   end

   // v*255 + residual
   always_comb begin
      res_use = ctrl.clear ? '0 : residual_ff;
      scaled  = {1'b0, clamped, {QUOT_BITS{1'b0}}} - REM_W'(clamped) + REM_W'(res_use);
   end

   // one restoring step per cycle, MSB of the quotient first
   always_comb begin
      div_sh = REM_W'(maxv) << ctrl.bit_idx;
      diff   = {1'b0, rem_ff} - {1'b0, div_sh};
      fits   = !diff[REM_W];
   end

   always_comb begin
      rem_in      = rem_ff;
      quot_in     = quot_ff;
      residual_in = residual_ff;
      if (ctrl.load) begin
         rem_in  = scaled;
         quot_in = '0;
      end else if (ctrl.step) begin
         if (fits) begin
            rem_in = diff[REM_W-1:0];
         end
         quot_in = {quot_ff[QUOT_BITS-2:0], fits};
         if (ctrl.last) begin
            residual_in = fits ? diff[MAX_BITS-1:0] : rem_ff[MAX_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         residual_ff <= '0;
      end else begin
         residual_ff <= residual_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
   end

   assign quot = quot_ff;

endmodule

`default_nettype wire

FILE: design/hrec_merge.sv
`default_nettype none

module hrec_merge (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   input  wire logic [hrec_pkg::QUOT_BITS-1:0] blue_q,
   input  wire logic [hrec_pkg::QUOT_BITS-1:0] green_q,
   input  wire logic [hrec_pkg::QUOT_BITS-1:0] red_q,
   output logic                                free,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic      [hrec_pkg::QUOT_BITS-1:0] rsp_blue_out,
   output logic      [hrec_pkg::QUOT_BITS-1:0] rsp_green_out,
   output logic      [hrec_pkg::QUOT_BITS-1:0] rsp_red_out
);
   import hrec_pkg::*;

   logic                 valid_ff, valid_in;
   logic [QUOT_BITS-1:0] blue_ff, green_ff, red_ff;

   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         blue_ff  <= blue_q;
         green_ff <= green_q;
         red_ff   <= red_q;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_green_out = green_ff;
   assign rsp_red_out   = red_ff;

endmodule

`default_nettype wire

FILE: design/hdr_to_rgb8_error_carry_core.sv
`default_nettype none

// Reduces one signed HDR pixel per word (blue, green, red plus a shared offset)
// to 8-bit BGR with per-colour error carry. Each colour has offset added, is
// clamped to 0..max_value and scaled as floor((v*255 + residual)/max_value),
// saturating at 255; the remainder is carried to the next pixel of the same
// colour. A word with frame_start set clears the residuals first. A max_value
// of 0 acts as 1. The three colours run in parallel lanes, each with a
// restoring divider resolving one quotient bit per cycle, so a pixel passes
// through a load, the divide steps and a hand-off; the next word is taken in
// the hand-off cycle while the result register is drained. The result sits
// in an output register so the next pixel can start while it waits.
// csr_max_value must only be written while the block is idle.
module hdr_to_rgb8_error_carry_core #(
   parameter int SAMPLE_BITS = 20,
   parameter int MAX_BITS    = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,

   input  wire logic                          csr_write,
   input  wire logic        [MAX_BITS-1:0]    csr_max_value,

   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_frame_start,
   input  wire logic signed [SAMPLE_BITS-1:0] req_blue_in,
   input  wire logic signed [SAMPLE_BITS-1:0] req_green_in,
   input  wire logic signed [SAMPLE_BITS-1:0] req_red_in,
   input  wire logic signed [SAMPLE_BITS-1:0] req_offset_in,

   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic             [7:0]             rsp_blue_out,
   output logic             [7:0]             rsp_green_out,
   output logic             [7:0]             rsp_red_out
);
   import hrec_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_HOLD = 2'd2;

   localparam logic [MAX_BITS-1:0] MAX_RESET = MAX_BITS'(4095);

   logic [1:0]           state_ff, state_in;
   logic [QIDX_BITS-1:0] count_ff, count_in;
   logic [MAX_BITS-1:0]  max_ff, max_in;
   logic [MAX_BITS-1:0]  max_eff;

   logic                 accept;
   logic                 push;
   logic                 free;
   lane_ctrl_type        ctrl;
   logic [QUOT_BITS-1:0] blue_q, green_q, red_q;

   assign max_in  = csr_write ? csr_max_value : max_ff;
   assign max_eff = (max_ff == '0) ? MAX_BITS'(1) : max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff <= MAX_RESET;
      end else begin
         max_ff <= max_in;
      end
   end

   assign push      = (state_ff == ST_HOLD) && free;
   assign req_ready = (state_ff == ST_IDLE) || push;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ctrl.clear   = req_frame_start;
      ctrl.load    = accept;
      ctrl.step    = (state_ff == ST_CALC);
      ctrl.last    = (count_ff == '0);
      ctrl.bit_idx = count_ff;
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CALC;
               count_in = '1;
            end
         end
         ST_CALC: begin
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (accept) begin
               state_in = ST_CALC;
               count_in = '1;
            end else if (push) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   hrec_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_BITS    (MAX_BITS)
   ) u_lane_blue (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .colour (req_blue_in),
      .offset (req_offset_in),
      .maxv   (max_eff),
      .quot   (blue_q)
   );

   hrec_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_BITS    (MAX_BITS)
   ) u_lane_green (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .colour (req_green_in),
      .offset (req_offset_in),
      .maxv   (max_eff),
      .quot   (green_q)
   );

   hrec_lane #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .MAX_BITS    (MAX_BITS)
   ) u_lane_red (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .colour (req_red_in),
      .offset (req_offset_in),
      .maxv   (max_eff),
      .quot   (red_q)
   );

   hrec_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .push          (push),
      .blue_q        (blue_q),
      .green_q       (green_q),
      .red_q         (red_q),
      .free          (free),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_blue_out  (rsp_blue_out),
      .rsp_green_out (rsp_green_out),
      .rsp_red_out   (rsp_red_out)
   );

endmodule

`default_nettype wire

FILE: bench/hdr_to_rgb8_error_carry_core_tb.sv
module hdr_to_rgb8_error_carry_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLE_BITS = 20;
   localparam int MAX_BITS    = 16;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_WORDS = 65;

   typedef struct {
      logic                          fs;
      logic signed [SAMPLE_BITS-1:0] blue;
      logic signed [SAMPLE_BITS-1:0] green;
      logic signed [SAMPLE_BITS-1:0] red;
      logic signed [SAMPLE_BITS-1:0] offs;
   } pixel_word_type;

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rgb8_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                          csr_write       = 1'b0;
   logic [MAX_BITS-1:0]           csr_max_value   = '0;
   logic                          req_valid       = 1'b0;
   logic                          req_ready;
   logic                          req_frame_start = 1'b0;
   logic signed [SAMPLE_BITS-1:0] req_blue_in     = '0;
   logic signed [SAMPLE_BITS-1:0] req_green_in    = '0;
   logic signed [SAMPLE_BITS-1:0] req_red_in      = '0;
   logic signed [SAMPLE_BITS-1:0] req_offset_in   = '0;
   logic                          rsp_valid;
   logic                          rsp_ready       = 1'b0;
   logic [7:0]                    rsp_blue_out;
   logic [7:0]                    rsp_green_out;
   logic [7:0]                    rsp_red_out;

   hdr_to_rgb8_error_carry_core #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .MAX_BITS   (MAX_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_max_value  (csr_max_value),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_frame_start(req_frame_start),
      .req_blue_in    (req_blue_in),
      .req_green_in   (req_green_in),
      .req_red_in     (req_red_in),
      .req_offset_in  (req_offset_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_green_out  (rsp_green_out),
      .rsp_red_out    (rsp_red_out)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   pixel_word_type      pixel_fifo[$];
   rgb8_type            rgb_due_q[$];
   pixel_word_type      held_word;
   logic [MAX_BITS-1:0] model_max = 16'd4095;
   logic [MAX_BITS-1:0] colour_rem[3] = '{default: '0};

   int burst_left   = 1;
   int gap_left     = 0;
   int words_sent   = 0;
   int frame_starts = 0;
   int words_seen   = 0;
   int errors       = 0;
   int settings     = 0;
   int sink_cycle   = 0;
   int cycle_count  = 0;

   // returns {new remainder, 8-bit result}
   function automatic logic [MAX_BITS+7:0] carry_colour(
      input logic signed [SAMPLE_BITS-1:0] colour,
      input logic signed [SAMPLE_BITS-1:0] offs,
      input logic [MAX_BITS-1:0]           full,
      input logic [MAX_BITS-1:0]           rem);
      longint m, v, s, t;
      logic [MAX_BITS-1:0] rem_next;
      m = (full == '0) ? 1 : longint'(full);
      v = longint'(colour) + longint'(offs);
      if (v < 0) v = 0;
      if (v > m) v = m;
      s = v * 255 + longint'(rem);
      t = s / m;
      if (t > 255) t = 255;
      rem_next = MAX_BITS'(s - t * m);
      return {rem_next, 8'(t)};
   endfunction

   task automatic predict_pixel(input pixel_word_type p);
      logic [MAX_BITS+7:0] b, g, r;
      rgb8_type due;
      if (p.fs) begin
         colour_rem = '{default: '0};
      end
      b = carry_colour(p.blue,  p.offs, model_max, colour_rem[0]);
      g = carry_colour(p.green, p.offs, model_max, colour_rem[1]);
      r = carry_colour(p.red,   p.offs, model_max, colour_rem[2]);
      colour_rem[0] = b[MAX_BITS+7:8];
      colour_rem[1] = g[MAX_BITS+7:8];
      colour_rem[2] = r[MAX_BITS+7:8];
      due.blue  = b[7:0];
      due.green = g[7:0];
      due.red   = r[7:0];
      rgb_due_q.push_back(due);
   endtask

   // sender: bursts of random length with random gaps
   always @(posedge clock) begin : drive_proc
      pixel_word_type nxt;
      logic           fire;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         fire = req_valid && req_ready;
         if (fire) begin
            predict_pixel(held_word);
            words_sent++;
            if (held_word.fs) frame_starts++;
         end
         if (!req_valid || fire) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_fifo.size() > 0) begin
               nxt = pixel_fifo.pop_front();
               held_word       = nxt;
               req_valid       <= 1'b1;
               req_frame_start <= nxt.fs;
               req_blue_in     <= nxt.blue;
               req_green_in    <= nxt.green;
               req_red_in      <= nxt.red;
               req_offset_in   <= nxt.offs;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each word and stalls on a rotating pattern
   always @(posedge clock) begin : check_proc
      rgb8_type want;
      int       mode;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            words_seen++;
            if (rgb_due_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected word blue %0d green %0d red %0d",
                        $realtime, rsp_blue_out, rsp_green_out, rsp_red_out);
            end else begin
               want = rgb_due_q.pop_front();
               if (rsp_blue_out !== want.blue) begin
                  errors++;
                  $display("%0t: blue expected %0d actual %0d",
                           $realtime, want.blue, rsp_blue_out);
               end
               if (rsp_green_out !== want.green) begin
                  errors++;
                  $display("%0t: green expected %0d actual %0d",
                           $realtime, want.green, rsp_green_out);
               end
               if (rsp_red_out !== want.red) begin
                  errors++;
                  $display("%0t: red expected %0d actual %0d",
                           $realtime, want.red, rsp_red_out);
               end
            end
         end
         sink_cycle++;
         mode = (sink_cycle / 277) % 4;
         case (mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= $urandom_range(0, 1);
            end
            2: begin
               rsp_ready <= (sink_cycle % 13) < 5;
            end
            default: begin
               rsp_ready <= $urandom_range(0, 7) != 0;
            end
         endcase
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("hdr_to_rgb8_error_carry_core_tb NOT OK");
         $finish;
      end
   end

   function automatic pixel_word_type mk_pixel(input logic fs, input int b, input int g,
                                               input int r, input int o);
      pixel_word_type p;
      p.fs    = fs;
      p.blue  = SAMPLE_BITS'(b);
      p.green = SAMPLE_BITS'(g);
      p.red   = SAMPLE_BITS'(r);
      p.offs  = SAMPLE_BITS'(o);
      return p;
   endfunction

   function automatic int rand_colour(input int m);
      case ($urandom_range(0, 9))
         0: return int'(SAMPLE_BITS'($urandom)) - ((($urandom & 1) != 0) ? 0 : 0);
         1: return ($urandom_range(0, 1) != 0) ? 524287 : -524288;
         2: return m;
         default: return int'($urandom_range(0, 2 * m)) - m / 2;
      endcase
   endfunction

   function automatic int rand_offset(input int m);
      case ($urandom_range(0, 9))
         0: return int'($urandom);
         1: return ($urandom_range(0, 1) != 0) ? 524287 : -524288;
         2, 3, 4, 5: return 0;
         default: return int'($urandom_range(0, m / 2)) - m / 4;
      endcase
   endfunction

   task automatic queue_random(input int n, input logic [MAX_BITS-1:0] full);
      int m;
      m = (full == '0) ? 1 : int'(full);
      repeat (n) begin
         pixel_fifo.push_back(mk_pixel($urandom_range(0, 19) == 0, rand_colour(m),
                                       rand_colour(m), rand_colour(m), rand_offset(m)));
      end
   endtask

   task automatic write_max(input logic [MAX_BITS-1:0] val);
      @(posedge clock);
      csr_write     <= 1'b1;
      csr_max_value <= val;
      model_max     = val;
      settings++;
      @(posedge clock);
      csr_write     <= 1'b0;
   endtask

   task automatic wait_drained;
      do @(posedge clock);
      while (pixel_fifo.size() != 0 || req_valid || rgb_due_q.size() != 0);
      repeat (20) @(posedge clock);
   endtask

   logic [MAX_BITS-1:0] rand_max_list[10];

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset value 4095: clamps, extremes, carry build-up, mid-stream clear
      pixel_fifo.push_back(mk_pixel(1'b1, 0, 0, 0, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 4095, 4094, 4096, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 524287, -524288, 2000, 524287));
      pixel_fifo.push_back(mk_pixel(1'b0, -524288, -524288, -524288, -524288));
      pixel_fifo.push_back(mk_pixel(1'b0, 1, 2, 3, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 1, 2, 3, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 1, 2, 3, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 100, -50, 0, 50));
      pixel_fifo.push_back(mk_pixel(1'b1, 1, 1, 1, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 2048, 2047, 0, -1));
      wait_drained();

      // zero max_value acts as one
      write_max(16'd0);
      pixel_fifo.push_back(mk_pixel(1'b1, 0, 1, -1, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 5, 0, 1, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 524287, 1, 0, -1));
      wait_drained();

      // full scale, then shrink max_value mid-frame so large residuals saturate
      write_max(16'd65535);
      pixel_fifo.push_back(mk_pixel(1'b1, 65534, 65535, 1, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 30000, 40000, 65533, 1));
      pixel_fifo.push_back(mk_pixel(1'b0, 12345, 257, 65535, -2));
      wait_drained();
      write_max(16'd7);
      pixel_fifo.push_back(mk_pixel(1'b0, 7, 0, 3, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 0, 7, 6, 0));
      pixel_fifo.push_back(mk_pixel(1'b0, 3, 3, 3, 1));
      wait_drained();

      rand_max_list = '{16'd255, 16'd1, 16'd65535, 16'd1023, 16'd0, 16'd3,
                        16'($urandom_range(2, 65534)), 16'd4095, 16'd65534,
                        16'($urandom_range(8, 300))};
      foreach (rand_max_list[i]) begin
         write_max(rand_max_list[i]);
         queue_random(PHASE_WORDS, rand_max_list[i]);
         wait_drained();
      end

      if (rgb_due_q.size() != 0) begin
         errors++;
         $display("%0t: %0d words never returned", $realtime, rgb_due_q.size());
      end
      $display("%0d pixels (%0d with frame start) under %0d max_value settings, %0d checked",
               words_sent, frame_starts, settings, words_seen);
      $display("sender bursts/gaps and receiver stalls mixed, %0d mismatches", errors);
      if (errors == 0) begin
         $display("hdr_to_rgb8_error_carry_core_tb OK");
      end else begin
         $display("hdr_to_rgb8_error_carry_core_tb NOT OK");
      end
      $finish;
   end

endmodule
